// ----- rtl/eat_pkg.sv -----
// Shared types and constants for the elliptic arc tessellator.
// Used by eat_ctrl, eat_dp and the top level; no dependencies.
`timescale 1ns / 1ps
package eat_pkg;

  localparam logic signed [34:0] TWO_PI_Q28     = 35'sd1686629713;
  localparam logic signed [34:0] HALF_PI_Q30    = 35'sd1686629713;
  localparam logic signed [34:0] QUARTER_PI_Q30 = 35'sd843314856;
  localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
  localparam logic [5:0]         MAX_SEGMENTS   = 6'd63;
  localparam int                 DIV_W          = 38;
  localparam int                 SQRT_STEPS     = 32;

  typedef enum logic [5:0] {
    C_NONE, C_LOAD, C_MUL_AX, C_MUL_AY, C_SQRT_GO, C_SW_INIT, C_SW_RED, C_SW_SET,
    C_STEPS_ONE, C_N_ONE, C_DIV_SAG, C_ANG_SAG, C_MUL_DROP, C_STEPS_N, C_INC_N,
    C_MUL_SWK, C_DIV_PT, C_ANG_PT, C_ANG_RED, C_QUAD_INIT, C_QUAD_STEP, C_FOLD,
    C_MUL_YY, C_SET_Y2, C_MUL_TY2, C_DIV_TERM, C_ACC_TERM, C_COS_INIT, C_SC_FINAL,
    C_MUL_RS, C_MUL_MXC, C_MUL_MYRS, C_MUL_MYC, C_MUL_MXRS, C_EMIT
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic rad_zero;
    logic sw_hi;
    logic sw_lo;
    logic ang_neg;
    logic ang_hi;
    logic x_ge_hp;
    logic term_last;
    logic cos_mode;
    logic sag_ok;
    logic n_max;
    logic tol_zero;
    logic out_free;
    logic k_last;
  } stat_t;

  // series term divisors: sine (2k)(2k+1), cosine (2k-1)(2k)
  function automatic logic [7:0] term_div(input logic cm, input logic [2:0] j);
    logic [7:0] d;
    d = 8'd1;
    case ({cm, j})
      4'b0001: d = 8'd6;
      4'b0010: d = 8'd20;
      4'b0011: d = 8'd42;
      4'b0100: d = 8'd72;
      4'b0101: d = 8'd110;
      4'b1001: d = 8'd2;
      4'b1010: d = 8'd12;
      4'b1011: d = 8'd30;
      4'b1100: d = 8'd56;
      4'b1101: d = 8'd90;
      4'b1110: d = 8'd132;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/eat_if.sv -----
// Valid/ready channel interfaces: arc descriptor in, tessellated point out.
// No dependencies.
`timescale 1ns / 1ps
interface eat_arc_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic signed [31:0] major_x;
  logic signed [31:0] major_y;
  logic signed [19:0] minor_ratio;
  logic signed [31:0] start_angle;
  logic signed [31:0] end_angle;
  logic               ccw;
  modport source(output valid, centre_x, centre_y, major_x, major_y, minor_ratio,
                 start_angle, end_angle, ccw, input ready);
  modport sink(input valid, centre_x, centre_y, major_x, major_y, minor_ratio,
               start_angle, end_angle, ccw, output ready);
endinterface

interface eat_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last;
  modport source(output valid, point_x, point_y, last, input ready);
  modport sink(input valid, point_x, point_y, last, output ready);
endinterface

// ----- rtl/eat_ctrl.sv -----
// Tessellator sequencer: one datapath command per cycle, none in waits.
// Depends on eat_pkg.
`timescale 1ns / 1ps
module eat_ctrl import eat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ1, S_SQ2, S_SQ3, S_SQW, S_CHK, S_SWR, S_TOL, S_SAG_DIV, S_SAG_DW,
    S_SAG_MUL, S_SAG_CMP, S_PT_MUL, S_PT_DIV, S_PT_DW, S_SC_RED, S_SC_Q, S_SC_YY,
    S_SC_Y2, S_SC_TM, S_SC_TD, S_SC_TW, S_SC_COS, S_SC_FIN, S_PT_RS, S_PT_MXC,
    S_PT_MYRS, S_PT_MYC, S_PT_MXRS, S_PT_OUT
  } state_t;

  state_t state, state_next;
  logic   pt_mode, pt_mode_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    pt_mode_next = pt_mode;
    cmd          = C_NONE;
    unique case (state)
      S_IDLE: if (in_valid) begin cmd = C_LOAD; state_next = S_SQ1; end
      S_SQ1: begin cmd = C_MUL_AX; state_next = S_SQ2; end
      S_SQ2: begin cmd = C_MUL_AY; state_next = S_SQ3; end
      S_SQ3: begin cmd = C_SQRT_GO; state_next = S_SQW; end
      S_SQW: if (!st.sqrt_busy) state_next = S_CHK;
      S_CHK: begin
        if (st.rad_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd = C_SW_INIT; state_next = S_SWR;
        end
      end
      S_SWR: begin
        if (st.sw_hi || st.sw_lo) begin
          cmd = C_SW_RED;
        end else begin
          cmd = C_SW_SET; state_next = S_TOL;
        end
      end
      S_TOL: begin
        if (st.tol_zero) begin
          cmd = C_STEPS_ONE; state_next = S_PT_MUL;
        end else begin
          cmd = C_N_ONE; state_next = S_SAG_DIV;
        end
      end
      S_SAG_DIV: begin cmd = C_DIV_SAG; state_next = S_SAG_DW; end
      S_SAG_DW: if (!st.div_busy) begin
        cmd = C_ANG_SAG; pt_mode_next = 1'b0; state_next = S_SC_RED;
      end
      S_SAG_MUL: begin cmd = C_MUL_DROP; state_next = S_SAG_CMP; end
      S_SAG_CMP: begin
        if (st.sag_ok || st.n_max) begin
          cmd = C_STEPS_N; state_next = S_PT_MUL;
        end else begin
          cmd = C_INC_N; state_next = S_SAG_DIV;
        end
      end
      S_PT_MUL: begin cmd = C_MUL_SWK; state_next = S_PT_DIV; end
      S_PT_DIV: begin cmd = C_DIV_PT; state_next = S_PT_DW; end
      S_PT_DW: if (!st.div_busy) begin
        cmd = C_ANG_PT; pt_mode_next = 1'b1; state_next = S_SC_RED;
      end
      S_SC_RED: begin
        if (st.ang_neg || st.ang_hi) begin
          cmd = C_ANG_RED;
        end else begin
          cmd = C_QUAD_INIT; state_next = S_SC_Q;
        end
      end
      S_SC_Q: begin
        if (st.x_ge_hp) begin
          cmd = C_QUAD_STEP;
        end else begin
          cmd = C_FOLD; state_next = S_SC_YY;
        end
      end
      S_SC_YY: begin cmd = C_MUL_YY; state_next = S_SC_Y2; end
      S_SC_Y2: begin cmd = C_SET_Y2; state_next = S_SC_TM; end
      S_SC_TM: begin cmd = C_MUL_TY2; state_next = S_SC_TD; end
      S_SC_TD: begin cmd = C_DIV_TERM; state_next = S_SC_TW; end
      S_SC_TW: if (!st.div_busy) begin
        cmd = C_ACC_TERM;
        if (!st.term_last) state_next = S_SC_TM;
        else if (st.cos_mode) state_next = S_SC_FIN;
        else state_next = S_SC_COS;
      end
      S_SC_COS: begin cmd = C_COS_INIT; state_next = S_SC_TM; end
      S_SC_FIN: begin
        cmd = C_SC_FINAL;
        state_next = pt_mode ? S_PT_RS : S_SAG_MUL;
      end
      S_PT_RS: begin cmd = C_MUL_RS; state_next = S_PT_MXC; end
      S_PT_MXC: begin cmd = C_MUL_MXC; state_next = S_PT_MYRS; end
      S_PT_MYRS: begin cmd = C_MUL_MYRS; state_next = S_PT_MYC; end
      S_PT_MYC: begin cmd = C_MUL_MYC; state_next = S_PT_MXRS; end
      S_PT_MXRS: begin cmd = C_MUL_MXRS; state_next = S_PT_OUT; end
      S_PT_OUT: if (st.out_free) begin
        cmd = C_EMIT;
        state_next = st.k_last ? S_IDLE : S_PT_MUL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pt_mode <= 1'b0;
    end else begin
      state   <= state_next;
      pt_mode <= pt_mode_next;
    end
  end

endmodule

// ----- rtl/eat_dp.sv -----
// Tessellator datapath: shared multiplier, serial divider and square root,
// sine/cosine series registers, config register and output register. Uses eat_pkg.
`timescale 1ns / 1ps
module eat_dp import eat_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic signed [31:0] centre_x,
  input  logic signed [31:0] centre_y,
  input  logic signed [31:0] major_x,
  input  logic signed [31:0] major_y,
  input  logic signed [19:0] minor_ratio,
  input  logic signed [31:0] start_angle,
  input  logic signed [31:0] end_angle,
  input  logic               ccw,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic               last
);

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -68'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic [30:0]        tol;
  logic signed [31:0] cx_r, cy_r, mx_r, my_r, start_r, end_r;
  logic signed [19:0] ratio_r;
  logic               ccw_r;
  logic [63:0]        acc;
  logic signed [67:0] mul_p, prod;
  logic signed [33:0] ma, mb;
  logic               mul_en;

  logic [63:0]        sq_v;
  logic [35:0]        sq_rem, sq_sh, sq_tr;
  logic [31:0]        sq_root;
  logic [4:0]         sq_cnt;
  logic               sq_busy;

  logic [DIV_W-1:0]   dv_num;
  logic [7:0]         dv_den, dv_rem;
  logic [8:0]         dv_tr;
  logic               dv_ge;
  logic [5:0]         dv_cnt;
  logic               dv_busy;

  logic signed [32:0] sr;
  logic signed [31:0] sweep;
  logic [30:0]        mag;
  logic [5:0]         steps, n, k;
  logic signed [34:0] ang;
  logic [1:0]         q;
  logic               swp;
  logic [29:0]        y, y2;
  logic [30:0]        t;
  logic [2:0]         j;
  logic               cos_mode;
  logic signed [31:0] ssum, csum, s, c, sx, cxv;
  logic signed [33:0] rs, drop, dr;
  logic signed [67:0] tx, pacc, ty;
  logic signed [34:0] qv;

  assign dr   = 34'sh4000_0000 - 34'(c);
  assign drop = dr[33] ? '0 : dr;
  assign sx   = swp ? csum : ssum;
  assign cxv  = swp ? ssum : csum;
  assign qv   = $signed({4'b0, dv_num[30:0]});

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd)
      C_MUL_AX:   begin ma = mx_r[31] ? -34'(mx_r) : 34'(mx_r); mb = ma; end
      C_MUL_AY:   begin ma = my_r[31] ? -34'(my_r) : 34'(my_r); mb = ma; end
      C_MUL_DROP: begin ma = $signed({2'b0, sq_root}); mb = drop; end
      C_MUL_SWK:  begin ma = $signed({3'b0, mag}); mb = $signed({28'b0, k}); end
      C_MUL_YY:   begin ma = $signed({4'b0, y}); mb = ma; end
      C_MUL_TY2:  begin ma = $signed({3'b0, t}); mb = $signed({4'b0, y2}); end
      C_MUL_RS:   begin ma = 34'(ratio_r); mb = 34'(s); end
      C_MUL_MXC:  begin ma = 34'(mx_r); mb = 34'(c); end
      C_MUL_MYRS: begin ma = 34'(my_r); mb = rs; end
      C_MUL_MYC:  begin ma = 34'(my_r); mb = 34'(c); end
      C_MUL_MXRS: begin ma = 34'(mx_r); mb = rs; end
      default:    mul_en = 1'b0;
    endcase
  end

  assign prod = ma * mb;

  assign sq_sh = {sq_rem[33:0], sq_v[63:62]};
  assign sq_tr = {2'b0, sq_root, 2'b01};
  assign dv_tr = {dv_rem, dv_num[DIV_W-1]};
  assign dv_ge = dv_tr >= {1'b0, dv_den};

  always_comb begin
    st.sqrt_busy = sq_busy;
    st.div_busy  = dv_busy;
    st.rad_zero  = (sq_root == '0);
    st.sw_hi     = sr > 33'(TWO_PI_Q28);
    st.sw_lo     = sr <= 33'sd0;
    st.ang_neg   = ang[34];
    st.ang_hi    = ang >= TWO_PI_Q28;
    st.x_ge_hp   = ang >= HALF_PI_Q30;
    st.term_last = cos_mode ? (j == 3'd6) : (j == 3'd5);
    st.cos_mode  = cos_mode;
    st.sag_ok    = $unsigned(mul_p) <= {7'b0, tol, 30'b0};
    st.n_max     = (n == MAX_SEGMENTS);
    st.tol_zero  = (tol == '0);
    st.out_free  = !out_valid || out_ready;
    st.k_last    = (k == steps);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= 31'd655;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) mul_p <= prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_root <= '0;
    end else if (cmd == C_SQRT_GO) begin
      sq_v    <= acc + mul_p[63:0];
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= '0;
      sq_busy <= 1'b1;
    end else if (sq_busy) begin
      sq_v <= {sq_v[61:0], 2'b00};
      if (sq_sh >= sq_tr) begin
        sq_rem  <= sq_sh - sq_tr;
        sq_root <= {sq_root[30:0], 1'b1};
      end else begin
        sq_rem  <= sq_sh;
        sq_root <= {sq_root[30:0], 1'b0};
      end
      sq_cnt <= sq_cnt + 5'd1;
      if (sq_cnt == 5'(SQRT_STEPS - 1)) sq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd == C_DIV_SAG || cmd == C_DIV_PT || cmd == C_DIV_TERM) begin
      dv_rem  <= '0;
      dv_cnt  <= '0;
      dv_busy <= 1'b1;
      case (cmd)
        C_DIV_SAG: begin dv_num <= DIV_W'(mag); dv_den <= {1'b0, n, 1'b0}; end
        C_DIV_PT:  begin dv_num <= mul_p[DIV_W-1:0]; dv_den <= {2'b0, steps}; end
        default: begin
          dv_num <= DIV_W'(mul_p[59:30]);
          dv_den <= term_div(cos_mode, j);
        end
      endcase
    end else if (dv_busy) begin
      dv_rem <= dv_ge ? 8'(dv_tr - {1'b0, dv_den}) : dv_tr[7:0];
      dv_num <= {dv_num[DIV_W-2:0], dv_ge};
      dv_cnt <= dv_cnt + 6'd1;
      if (dv_cnt == 6'(DIV_W - 1)) dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      C_LOAD: begin
        cx_r    <= centre_x;
        cy_r    <= centre_y;
        mx_r    <= major_x;
        my_r    <= major_y;
        ratio_r <= minor_ratio;
        start_r <= start_angle;
        end_r   <= end_angle;
        ccw_r   <= ccw;
      end
      C_MUL_AY:    acc <= mul_p[63:0];
      C_SW_INIT:   sr <= ccw_r ? 33'(end_r) - 33'(start_r) : 33'(start_r) - 33'(end_r);
      C_SW_RED:    sr <= (sr > 33'(TWO_PI_Q28)) ? sr - 33'(TWO_PI_Q28)
                                               : sr + 33'(TWO_PI_Q28);
      C_SW_SET: begin
        sweep <= ccw_r ? sr[31:0] : -sr[31:0];
        mag   <= sr[30:0];
      end
      C_STEPS_ONE: begin steps <= 6'd1; k <= '0; end
      C_N_ONE:     n <= 6'd1;
      C_STEPS_N:   begin steps <= n; k <= '0; end
      C_INC_N:     n <= n + 6'd1;
      C_ANG_SAG:   ang <= qv;
      C_ANG_PT:    ang <= 35'(start_r) + (sweep[31] ? -qv : qv);
      C_ANG_RED:   ang <= ang[34] ? ang + TWO_PI_Q28 : ang - TWO_PI_Q28;
      C_QUAD_INIT: begin ang <= ang <<< 2; q <= '0; end
      C_QUAD_STEP: begin ang <= ang - HALF_PI_Q30; q <= q + 2'd1; end
      C_FOLD: begin
        if (ang > QUARTER_PI_Q30) begin
          y   <= 30'(HALF_PI_Q30 - ang);
          swp <= 1'b1;
        end else begin
          y   <= ang[29:0];
          swp <= 1'b0;
        end
      end
      C_SET_Y2: begin
        y2       <= mul_p[59:30];
        t        <= {1'b0, y};
        ssum     <= $signed({2'b0, y});
        j        <= 3'd1;
        cos_mode <= 1'b0;
      end
      C_ACC_TERM: begin
        t <= dv_num[30:0];
        if (cos_mode) begin
          csum <= j[0] ? csum - $signed({1'b0, dv_num[30:0]})
                       : csum + $signed({1'b0, dv_num[30:0]});
        end else begin
          ssum <= j[0] ? ssum - $signed({1'b0, dv_num[30:0]})
                       : ssum + $signed({1'b0, dv_num[30:0]});
        end
        j <= j + 3'd1;
      end
      C_COS_INIT: begin
        t        <= ONE_Q30;
        csum     <= $signed({1'b0, ONE_Q30});
        j        <= 3'd1;
        cos_mode <= 1'b1;
      end
      C_SC_FINAL: begin
        case (q)
          2'd0:    begin s <= sx;   c <= cxv;  end
          2'd1:    begin s <= cxv;  c <= -sx;  end
          2'd2:    begin s <= -sx;  c <= -cxv; end
          default: begin s <= -cxv; c <= sx;   end
        endcase
      end
      C_MUL_MXC:  rs <= 34'((mul_p + 68'sd131072) >>> 18);
      C_MUL_MYRS: tx <= (mul_p + 68'sd2) >>> 2;
      C_MUL_MYC:  pacc <= tx - mul_p;
      C_MUL_MXRS: ty <= (mul_p + 68'sd2) >>> 2;
      C_EMIT:     k <= k + 6'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == C_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == C_EMIT) begin
      point_x <= sat32(68'(cx_r) + ((pacc + 68'sd134217728) >>> 28));
      point_y <= sat32(68'(cy_r) + ((ty + mul_p + 68'sd134217728) >>> 28));
      last    <= (k == steps);
    end
  end

endmodule

// ----- rtl/elliptic_arc_tessellator.sv -----
// Top level of the elliptic arc tessellator: sequencer plus datapath.
// Depends on eat_pkg, eat_if, eat_ctrl, eat_dp.
//
//   channel  dir  word                                         handshake
//   arc      in   centre, major axis, ratio, angles, ccw       valid/ready
//   pt       out  point_x, point_y, last                       valid/ready
//   cfg      in   sagitta_tolerance                            cfg_wr_en
//
// One arc at a time. The time per point emitted and per sagitta count tried is
// set by the serial divider run for each of the eleven series terms of every
// sine/cosine; the radius root is computed once per arc.
// Synchronous reset; the tolerance resets to 655. A stalled point holds in the
// output register while the next point is being computed.
`timescale 1ns / 1ps
module elliptic_arc_tessellator import eat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  eat_arc_if.sink     arc,
  eat_pt_if.source    pt,
  input  logic        cfg_wr_en,
  input  logic [30:0] cfg_wr_data
);

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  assign arc.ready = in_ready;

  eat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (arc.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  eat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .centre_x    (arc.centre_x),
    .centre_y    (arc.centre_y),
    .major_x     (arc.major_x),
    .major_y     (arc.major_y),
    .minor_ratio (arc.minor_ratio),
    .start_angle (arc.start_angle),
    .end_angle   (arc.end_angle),
    .ccw         (arc.ccw),
    .out_ready   (pt.ready),
    .out_valid   (pt.valid),
    .point_x     (pt.point_x),
    .point_y     (pt.point_y),
    .last        (pt.last)
  );

endmodule

// ----- rtl/eat_checker.sv -----
// Port-level checks for the elliptic arc tessellator, bound to the top level.
// No package dependencies.
`timescale 1ns / 1ps
module eat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic        out_last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("point valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("arc accepted while busy");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("stalled point changed");

endmodule

bind elliptic_arc_tessellator eat_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (arc.valid),
  .in_ready  (arc.ready),
  .out_valid (pt.valid),
  .out_ready (pt.ready),
  .out_x     (pt.point_x),
  .out_y     (pt.point_y),
  .out_last  (pt.last)
);
